@@ rtl/core/nec_ir_frame_decoder_defines.svh @@
// Assertion helpers shared by the decoder RTL.
`ifndef NEC_IR_FRAME_DECODER_DEFINES_SVH
`define NEC_IR_FRAME_DECODER_DEFINES_SVH

// Clocked property, masked while reset is held.
`define NECIR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be seen at a clock edge outside reset.
`define NECIR_NEVER(lbl, cond, msg) \
  `NECIR_ASSERT(lbl, !(cond), msg)

`endif

@@ rtl/core/necir_pkg.sv @@
package necir_pkg;

  localparam int FRAME_BITS = 32;
  localparam int CODE_W     = 32;
  localparam int CNT_W      = $clog2(FRAME_BITS + 1);
  localparam int TIME_W     = 16;
  localparam int NUM_CFG    = 8;
  localparam int CFG_IDX_W  = $clog2(NUM_CFG);
  localparam int BTN_LO     = 8;
  localparam int BTN_W      = 8;

  // Register map
  localparam logic [CFG_IDX_W-1:0] CFG_LEAD_MARK_MIN  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_LEAD_MARK_MAX  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_LEAD_SPACE_MIN = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_LEAD_SPACE_MAX = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] CFG_BIT_MARK_MIN   = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] CFG_BIT_MARK_MAX   = CFG_IDX_W'(5);
  localparam logic [CFG_IDX_W-1:0] CFG_BIT_SPACE_MAX  = CFG_IDX_W'(6);
  localparam logic [CFG_IDX_W-1:0] CFG_ONE_THRESHOLD  = CFG_IDX_W'(7);

  typedef logic [NUM_CFG-1:0][TIME_W-1:0] cfg_bank_t;

  // Entry i sits at bits [16*i +: 16]
  localparam cfg_bank_t CFG_RESET = {
    16'd1000, 16'd1800, 16'd700, 16'd400,
    16'd5000, 16'd4000, 16'd9500, 16'd8500
  };

  typedef enum logic [1:0] {
    MODE_EDGE    = 2'd0,
    MODE_TIMEOUT = 2'd1,
    MODE_REARM   = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    PH_IDLE       = 3'd0,
    PH_LEAD_MARK  = 3'd1,
    PH_LEAD_SPACE = 3'd2,
    PH_BIT_MARK   = 3'd3,
    PH_BIT_SPACE  = 3'd4
  } phase_t;

  typedef struct packed {
    logic [1:0]        mode;
    logic              rising;
    logic [TIME_W-1:0] elapsed;
  } necir_item_t;

  typedef struct packed {
    phase_t            phase;
    logic [CODE_W-1:0] code;
    logic [CNT_W-1:0]  cnt;
    logic              lock;
    logic [BTN_W-1:0]  button;
  } necir_state_t;

endpackage

@@ rtl/core/necir_step.sv @@
module necir_step
  import necir_pkg::*;
(
  input  necir_item_t  item,
  input  necir_state_t st,
  input  cfg_bank_t    cfg,
  output necir_state_t st_nxt,
  output logic         done
);

  logic              want_rising;
  logic              edge_take;
  logic [TIME_W-1:0] t;
  logic              lead_mark_ok;
  logic              lead_space_ok;
  logic              bit_mark_ok;
  logic              bit_space_ok;
  logic [CNT_W-1:0]  cnt_inc;
  logic              frame_end;
  logic [CODE_W-1:0] code_shift;
  mode_t             mode;

  assign mode        = mode_t'(item.mode);
  assign t           = item.elapsed;
  assign want_rising = (st.phase == PH_LEAD_MARK) || (st.phase == PH_BIT_MARK);
  assign edge_take   = (mode == MODE_EDGE) && !st.lock && (item.rising == want_rising);

  assign lead_mark_ok  = (t > cfg[CFG_LEAD_MARK_MIN])  && (t < cfg[CFG_LEAD_MARK_MAX]);
  assign lead_space_ok = (t > cfg[CFG_LEAD_SPACE_MIN]) && (t < cfg[CFG_LEAD_SPACE_MAX]);
  assign bit_mark_ok   = (t > cfg[CFG_BIT_MARK_MIN])   && (t < cfg[CFG_BIT_MARK_MAX]);
  assign bit_space_ok  = (t >= cfg[CFG_BIT_MARK_MIN])  && (t <= cfg[CFG_BIT_SPACE_MAX]);

  assign cnt_inc    = st.cnt + CNT_W'(1);
  assign frame_end  = cnt_inc >= CNT_W'(FRAME_BITS);
  assign code_shift = {st.code[CODE_W-2:0], (t > cfg[CFG_ONE_THRESHOLD])};

  // Phase sequencing
  always_comb begin
    st_nxt.phase = st.phase;
    unique case (mode)
      MODE_TIMEOUT: st_nxt.phase = PH_IDLE;
      MODE_EDGE: begin
        if (edge_take) begin
          unique case (st.phase)
            PH_IDLE:       st_nxt.phase = PH_LEAD_MARK;
            PH_LEAD_MARK:  st_nxt.phase = lead_mark_ok  ? PH_LEAD_SPACE : PH_IDLE;
            PH_LEAD_SPACE: st_nxt.phase = lead_space_ok ? PH_BIT_MARK   : PH_IDLE;
            PH_BIT_MARK:   st_nxt.phase = bit_mark_ok   ? PH_BIT_SPACE  : PH_IDLE;
            PH_BIT_SPACE:  st_nxt.phase = (bit_space_ok && !frame_end) ? PH_BIT_MARK
                                                                       : PH_IDLE;
            default:       st_nxt.phase = PH_IDLE;
          endcase
        end
      end
      default: st_nxt.phase = st.phase;
    endcase
  end

  // Shift register, bit count, lock and command byte
  always_comb begin
    st_nxt.code   = st.code;
    st_nxt.cnt    = st.cnt;
    st_nxt.lock   = st.lock;
    st_nxt.button = st.button;
    done          = 1'b0;
    if (mode == MODE_REARM) begin
      st_nxt.lock = 1'b0;
    end else if (edge_take && (st.phase == PH_IDLE)) begin
      st_nxt.code = '0;
      st_nxt.cnt  = '0;
    end else if (edge_take && (st.phase == PH_BIT_SPACE) && bit_space_ok) begin
      st_nxt.code = code_shift;
      st_nxt.cnt  = cnt_inc;
      if (frame_end) begin
        st_nxt.button = code_shift[BTN_LO +: BTN_W];
        st_nxt.lock   = 1'b1;
        done          = 1'b1;
      end
    end
  end

endmodule

@@ rtl/core/nec_ir_frame_decoder.sv @@
// Path: an accepted item is held in the input register, which feeds the step logic, whose
//   result loads the result register shown on out_* when that register is free or being emptied.
// Throughput: one item per cycle while out_stall is low; the decoder state loops through
//   the step logic once per item, so back-to-back items are taken with no gap.
// Reset: rst_n low at a clock edge (synchronous) returns to idle, unlocked, code, count
//   and command byte zero, and all thresholds to their default values.
`include "nec_ir_frame_decoder_defines.svh"

module nec_ir_frame_decoder
  import necir_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [TIME_W-1:0]    cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           in_mode,
  input  logic                 in_edge_rising,
  input  logic [TIME_W-1:0]    in_elapsed_us,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [2:0]           out_phase,
  output logic                 out_frame_done,
  output logic [CODE_W-1:0]    out_frame_code,
  output logic [BTN_W-1:0]     out_button,
  output logic                 out_locked
);

  cfg_bank_t    cfg_r;
  logic         in_v_r;
  necir_item_t  item_r;
  necir_state_t st_r;
  necir_state_t st_nxt;
  logic         done;
  logic         adv;
  logic         out_v_r;
  logic [2:0]   out_phase_r;
  logic         out_done_r;
  logic [CODE_W-1:0] out_code_r;
  logic [BTN_W-1:0]  out_button_r;
  logic         out_lock_r;

  // Process the held item whenever the result register is free or being emptied
  assign adv      = in_v_r && (!out_v_r || !out_stall);
  assign in_stall = in_v_r && !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_we) begin
      cfg_r[cfg_index] <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_v_r <= 1'b1;
    end else if (adv) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_r <= '{mode: in_mode, rising: in_edge_rising, elapsed: in_elapsed_us};
    end
  end

  necir_step u_step (
    .item   (item_r),
    .st     (st_r),
    .cfg    (cfg_r),
    .st_nxt (st_nxt),
    .done   (done)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '{phase: PH_IDLE, code: '0, cnt: '0, lock: 1'b0, button: '0};
    end else if (adv) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= 1'b1;
    end else if (!out_stall) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_phase_r  <= 3'(st_nxt.phase);
      out_done_r   <= done;
      out_code_r   <= st_nxt.code;
      out_button_r <= st_nxt.button;
      out_lock_r   <= st_nxt.lock;
    end
  end

  assign out_valid      = out_v_r;
  assign out_phase      = out_phase_r;
  assign out_frame_done = out_done_r;
  assign out_frame_code = out_code_r;
  assign out_button     = out_button_r;
  assign out_locked     = out_lock_r;

  `NECIR_ASSERT(a_done_locks, (out_v_r && out_done_r) |-> (out_lock_r && (out_phase_r == 3'(PH_IDLE))), "frame done without lock and idle")
  `NECIR_NEVER(a_cnt_range, st_r.cnt > CNT_W'(FRAME_BITS), "bit count past frame length")
  `NECIR_ASSERT(a_lock_holds, (st_r.lock && !(adv && (item_r.mode == 2'(MODE_REARM)))) |=> st_r.lock, "lock dropped without rearm")
  `NECIR_ASSERT(a_button_stable, (adv && !done) |=> $stable(st_r.button), "command byte changed without a frame")
  `NECIR_ASSERT(a_adv_fills_out, adv |=> out_v_r, "processed item did not reach the result register")

endmodule
